// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/qrc_pkg.sv =====
// ---------------------------------------------------------------------------
// qrc_pkg
// Shared constants, result codes and control types of the root classifier.
// ---------------------------------------------------------------------------
package qrc_pkg;

	localparam int COEF_WIDTH_DEF = 16;

	// Result field widths.
	localparam int KIND_W  = 2;
	localparam int MAG_W   = 33;
	localparam int DROOT_W = 17;
	localparam int RNUM_W  = 17;
	localparam int DEN_W   = 17;
	localparam int PNUM_W  = 18;

	// Root kind codes.
	localparam logic [KIND_W-1:0] KIND_DOUBLE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REAL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPLEX = 2'd2;

	typedef struct packed {
		logic load;     // capture the coefficients
		logic mul;      // form b*b and a*c
		logic disc;     // form the discriminant
		logic mag;      // take the magnitude and seed the square root
		logic sqrt;     // one square-root iteration
		logic out_load; // load the result register
	} qrc_cmd_t;

	typedef struct packed {
		logic out_busy; // result register holds a result that is stalled
	} qrc_status_t;

endpackage

// ===== src/quadratic_root_classifier.sv =====
// ---------------------------------------------------------------------------
// quadratic_root_classifier
// Classifies the roots of a*x^2 + b*x + c and gives the exact discriminant,
// its integer square root and the root numerators over the denominator 2a.
// ---------------------------------------------------------------------------
//
//  Channel  Handshake                  Fields
//  coef     coef_valid / coef_stall    coef_a, coef_b, coef_c
//  result   result_valid / result_stall root_kind ... root_minus_numerator
//
// One item is in work at a time. After the coefficient transfer the block
// forms the products, the discriminant and the magnitude in turn, then one
// root bit per cycle in the square-root step, and then loads the result
// register. coef_stall stays high from the transfer until the result is
// loaded; a stalled result holds the sequencer in its last step. Reset
// clears only the sequencer and the result valid flag.
//
module quadratic_root_classifier import qrc_pkg::*; #(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         coef_valid,
	output logic                         coef_stall,
	input  logic signed [COEF_WIDTH-1:0] coef_a,
	input  logic signed [COEF_WIDTH-1:0] coef_b,
	input  logic signed [COEF_WIDTH-1:0] coef_c,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [KIND_W-1:0]            root_kind,
	output logic                         leading_zero,
	output logic                         perfect_square,
	output logic [MAG_W-1:0]             disc_magnitude,
	output logic [DROOT_W-1:0]           disc_root,
	output logic signed [RNUM_W-1:0]     real_numerator,
	output logic signed [DEN_W-1:0]      denominator,
	output logic signed [PNUM_W-1:0]     root_plus_numerator,
	output logic signed [PNUM_W-1:0]     root_minus_numerator
);

	`include "assert_macros.svh"

	localparam int DISC_W = (2 * COEF_WIDTH + 2 > 64) ? 64 : 2 * COEF_WIDTH + 2;
	localparam int ROOT_W = DISC_W / 2;

	qrc_cmd_t    cmd;
	qrc_status_t status;

	qrc_ctrl #(
		.ROOT_W(ROOT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_valid(coef_valid),
		.coef_stall(coef_stall),
		.status    (status),
		.cmd       (cmd)
	);

	qrc_datapath #(
		.COEF_WIDTH(COEF_WIDTH)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.coef_a              (coef_a),
		.coef_b              (coef_b),
		.coef_c              (coef_c),
		.cmd                 (cmd),
		.status              (status),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.root_kind           (root_kind),
		.leading_zero        (leading_zero),
		.perfect_square      (perfect_square),
		.disc_magnitude      (disc_magnitude),
		.disc_root           (disc_root),
		.real_numerator      (real_numerator),
		.denominator         (denominator),
		.root_plus_numerator (root_plus_numerator),
		.root_minus_numerator(root_minus_numerator)
	);

	// A coefficient transfer makes the block busy in the next cycle.
	`QRC_ASSERT_NEXT(a_busy_after_transfer, coef_valid && !coef_stall, coef_stall, "block not busy after a coefficient transfer")

	// A new result never overwrites one that is still stalled.
	`QRC_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(result_valid && result_stall), "stalled result overwritten")

	// Complex roots carry no real root numerators.
	`QRC_ASSERT_NOW(a_complex_zero, result_valid && (root_kind == KIND_COMPLEX), (root_plus_numerator == '0) && (root_minus_numerator == '0), "complex result with nonzero root numerators")

	// A double root means a zero discriminant.
	`QRC_ASSERT_NOW(a_double_zero, result_valid && (root_kind == KIND_DOUBLE), (disc_magnitude == '0) && (disc_root == '0), "double root with nonzero discriminant")

endmodule

// ===== src/qrc_ctrl.sv =====
// ---------------------------------------------------------------------------
// qrc_ctrl
// Sequencer for the root classifier: walks the datapath through product,
// discriminant, magnitude and square-root steps for one item at a time.
// ---------------------------------------------------------------------------
module qrc_ctrl import qrc_pkg::*; #(
	parameter int ROOT_W = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        coef_valid,
	output logic        coef_stall,
	input  qrc_status_t status,
	output qrc_cmd_t    cmd
);

	localparam int CNT_W = $clog2(ROOT_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DISC,
		S_MAG,
		S_SQRT,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] iter_q;
	logic             last_iter;

	assign last_iter = (iter_q == CNT_W'(ROOT_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (coef_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_DISC;
				S_DISC: state_q <= S_MAG;
				S_MAG: begin
					iter_q  <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					iter_q <= iter_q + 1'b1;
					if (last_iter) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!status.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign coef_stall = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && coef_valid;
		cmd.mul      = (state_q == S_MUL);
		cmd.disc     = (state_q == S_DISC);
		cmd.mag      = (state_q == S_MAG);
		cmd.sqrt     = (state_q == S_SQRT);
		cmd.out_load = (state_q == S_DONE) && !status.out_busy;
	end

endmodule

// ===== src/qrc_datapath.sv =====
// ---------------------------------------------------------------------------
// qrc_datapath
// Coefficient registers, products, discriminant, bit-serial integer square
// root and the result register of the root classifier.
// ---------------------------------------------------------------------------
module qrc_datapath import qrc_pkg::*; #(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [COEF_WIDTH-1:0] coef_a,
	input  logic signed [COEF_WIDTH-1:0] coef_b,
	input  logic signed [COEF_WIDTH-1:0] coef_c,
	input  qrc_cmd_t                     cmd,
	output qrc_status_t                  status,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [KIND_W-1:0]            root_kind,
	output logic                         leading_zero,
	output logic                         perfect_square,
	output logic [MAG_W-1:0]             disc_magnitude,
	output logic [DROOT_W-1:0]           disc_root,
	output logic signed [RNUM_W-1:0]     real_numerator,
	output logic signed [DEN_W-1:0]      denominator,
	output logic signed [PNUM_W-1:0]     root_plus_numerator,
	output logic signed [PNUM_W-1:0]     root_minus_numerator
);

	// The discriminant needs 2W+2 bits; beyond 64 bits it wraps.
	localparam int DISC_W = (2 * COEF_WIDTH + 2 > 64) ? 64 : 2 * COEF_WIDTH + 2;
	localparam int ROOT_W = DISC_W / 2;
	localparam int PROD_W = 2 * COEF_WIDTH;

	logic signed [COEF_WIDTH-1:0] a_q, b_q, c_q;
	logic signed [PROD_W-1:0]     bb_q, ac_q;
	logic signed [DISC_W-1:0]     disc_q;
	logic [DISC_W-1:0]            mag_q, rem_q, res_q, bit_q;
	logic                         neg_q, zero_q;
	logic                         valid_q;

	logic [DISC_W-1:0]            mag_next;
	logic [DISC_W-1:0]            trial;
	logic [ROOT_W-1:0]            root;

	assign mag_next = disc_q[DISC_W-1] ? DISC_W'(-disc_q) : DISC_W'(disc_q);
	assign trial    = res_q + bit_q;
	assign root     = res_q[ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= coef_a;
			b_q <= coef_b;
			c_q <= coef_c;
		end
		if (cmd.mul) begin
			bb_q <= b_q * b_q;
			ac_q <= a_q * c_q;
		end
		if (cmd.disc) begin
			disc_q <= DISC_W'(bb_q) - (DISC_W'(ac_q) <<< 2);
		end
		if (cmd.mag) begin
			mag_q  <= mag_next;
			rem_q  <= mag_next;
			res_q  <= '0;
			bit_q  <= {2'b01, {(DISC_W-2){1'b0}}};
			neg_q  <= disc_q[DISC_W-1];
			zero_q <= (disc_q == '0);
		end
		// One result bit per step: subtract the trial value when it fits.
		if (cmd.sqrt) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// Result register.
	logic signed [63:0] nb_w, den_w, root_w;

	always_comb begin
		nb_w   = -(64'(b_q));
		den_w  = 64'(a_q) <<< 1;
		root_w = signed'(64'(root));
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (zero_q) begin
				root_kind <= KIND_DOUBLE;
			end else if (neg_q) begin
				root_kind <= KIND_COMPLEX;
			end else begin
				root_kind <= KIND_REAL;
			end
			leading_zero   <= (a_q == '0);
			perfect_square <= (rem_q == '0);
			disc_magnitude <= MAG_W'(mag_q);
			disc_root      <= DROOT_W'(root);
			real_numerator <= RNUM_W'(nb_w);
			denominator    <= DEN_W'(den_w);
			if (neg_q) begin
				root_plus_numerator  <= '0;
				root_minus_numerator <= '0;
			end else begin
				root_plus_numerator  <= PNUM_W'(nb_w + root_w);
				root_minus_numerator <= PNUM_W'(nb_w - root_w);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign result_valid    = valid_q;
	assign status.out_busy = valid_q && result_stall;

endmodule

// ===== bench/tb_quadratic_root_classifier.sv =====
// ---------------------------------------------------------------------------
// tb_quadratic_root_classifier
// Self-checking bench for the root classifier. Coefficient sets go through
// the valid/stall channel with random gaps, results are taken with random
// stalls, and each result transfer is compared field by field with a
// prediction worked out from the coefficients when they were accepted.
// ---------------------------------------------------------------------------
module tb_quadratic_root_classifier;
	import qrc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COEF_WIDTH_DEF;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic               lead_zero;
		logic               perfect;
		logic [MAG_W-1:0]   mag;
		logic [DROOT_W-1:0] root;
		logic [RNUM_W-1:0]  real_num;
		logic [DEN_W-1:0]   den;
		logic [PNUM_W-1:0]  plus_num;
		logic [PNUM_W-1:0]  minus_num;
	} root_set_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 coef_valid = 1'b0;
	logic                 coef_stall;
	logic signed [CW-1:0] coef_a = '0;
	logic signed [CW-1:0] coef_b = '0;
	logic signed [CW-1:0] coef_c = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [KIND_W-1:0]    root_kind;
	logic                 leading_zero;
	logic                 perfect_square;
	logic [MAG_W-1:0]     disc_magnitude;
	logic [DROOT_W-1:0]   disc_root;
	logic signed [RNUM_W-1:0] real_numerator;
	logic signed [DEN_W-1:0]  denominator;
	logic signed [PNUM_W-1:0] root_plus_numerator;
	logic signed [PNUM_W-1:0] root_minus_numerator;

	root_set_t pending_roots[$];
	int        mismatches = 0;
	bit        gapless = 1'b0;
	bit        hold_off_req = 1'b0;
	int        edge_vals[6] = '{-32768, -32767, -1, 0, 1, 32767};

	quadratic_root_classifier #(.COEF_WIDTH(CW)) u_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.coef_valid           (coef_valid),
		.coef_stall           (coef_stall),
		.coef_a               (coef_a),
		.coef_b               (coef_b),
		.coef_c               (coef_c),
		.result_valid         (result_valid),
		.result_stall         (result_stall),
		.root_kind            (root_kind),
		.leading_zero         (leading_zero),
		.perfect_square       (perfect_square),
		.disc_magnitude       (disc_magnitude),
		.disc_root            (disc_root),
		.real_numerator       (real_numerator),
		.denominator          (denominator),
		.root_plus_numerator  (root_plus_numerator),
		.root_minus_numerator (root_minus_numerator)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Largest root whose square does not exceed m, built one bit at a time.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] m);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int i = 20; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= m)
				root = trial;
		end
		return root;
	endfunction

	function automatic root_set_t predict_roots(input logic signed [CW-1:0] a, b, c);
		root_set_t   r;
		longint      sa;
		longint      sb;
		longint      sc;
		longint      disc;
		logic [63:0] mag;
		logic [63:0] root;
		logic [63:0] nb;
		logic [63:0] den;
		logic [63:0] plus;
		logic [63:0] minus;
		sa = a;
		sb = b;
		sc = c;
		disc = sb * sb - 4 * sa * sc;
		mag = (disc < 0) ? -disc : disc;
		root = floor_sqrt(mag);
		nb = -sb;
		den = 2 * sa;
		plus = '0;
		minus = '0;
		if (disc >= 0) begin
			plus = nb + root;
			minus = nb - root;
		end
		if (disc == 0)
			r.kind = KIND_DOUBLE;
		else if (disc < 0)
			r.kind = KIND_COMPLEX;
		else
			r.kind = KIND_REAL;
		r.lead_zero = (sa == 0);
		r.perfect = (root * root == mag);
		r.mag = mag[MAG_W-1:0];
		r.root = root[DROOT_W-1:0];
		r.real_num = nb[RNUM_W-1:0];
		r.den = den[DEN_W-1:0];
		r.plus_num = plus[PNUM_W-1:0];
		r.minus_num = minus[PNUM_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	function automatic int pick_gap();
		int roll;
		if (gapless)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one coefficient set and returns at the edge that accepts it. When
	// no gap is drawn, valid stays high straight into the next transfer.
	task automatic send_coefs(input logic signed [CW-1:0] a, b, c);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			coef_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		coef_valid <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		do @(posedge clk); while (coef_stall);
		pending_roots.push_back(predict_roots(a, b, c));
	endtask

	// Mostly shaped coefficient sets, so that double roots, integer roots and
	// exact complex parts show up far more often than pure chance allows.
	task automatic make_random_coefs(output logic signed [CW-1:0] a, b, c);
		int sel;
		int k;
		int p;
		int q;
		sel = $urandom_range(0, 99);
		a = CW'($urandom);
		b = CW'($urandom);
		c = CW'($urandom);
		if (sel < 30) begin
		end else if (sel < 45) begin
			a = '0;
		end else if (sel < 60) begin
			p = $urandom_range(1, 127);
			q = $urandom_range(1, 127);
			k = $urandom_range(0, 1) ? 1 : -1;
			a = CW'(k * p * p);
			c = CW'(k * q * q);
			b = CW'(($urandom_range(0, 1) ? 2 : -2) * p * q);
		end else if (sel < 80) begin
			k = $urandom_range(1, 20) * ($urandom_range(0, 1) ? 1 : -1);
			p = $urandom_range(0, 80) - 40;
			q = $urandom_range(0, 80) - 40;
			a = CW'(k);
			b = CW'(-k * (p + q));
			c = CW'(k * p * q);
		end else if (sel < 90) begin
			k = $urandom_range(1, 10) * ($urandom_range(0, 1) ? 1 : -1);
			p = $urandom_range(0, 80) - 40;
			q = $urandom_range(1, 40);
			a = CW'(k);
			b = CW'(-2 * k * p);
			c = CW'(k * (p * p + q * q));
		end else begin
			a = CW'(edge_vals[$urandom_range(0, 5)]);
			b = CW'(edge_vals[$urandom_range(0, 5)]);
			c = CW'(edge_vals[$urandom_range(0, 5)]);
		end
	endtask

	task automatic test_coef_extremes();
		send_coefs(-32768, -32768, 32767);
		send_coefs(-32768, 0, -32768);
		send_coefs(32767, -32768, -32768);
		send_coefs(32767, 32767, 32767);
		send_coefs(-32768, 32767, -32768);
		send_coefs(-1, -1, -1);
		send_coefs(1, -32768, 0);
	endtask

	task automatic test_leading_zero();
		send_coefs(0, 0, 0);
		send_coefs(0, 5, 7);
		send_coefs(0, -32768, 32767);
	endtask

	task automatic test_double_root();
		send_coefs(1, 2, 1);
		send_coefs(4, -4, 1);
		send_coefs(16129, 32258, 16129);
		send_coefs(-16129, -32258, -16129);
	endtask

	task automatic test_real_roots();
		send_coefs(1, -3, 2);
		send_coefs(1, 0, -2);
		send_coefs(-3, 7, 11);
	endtask

	task automatic test_complex_roots();
		send_coefs(1, 0, 1);
		send_coefs(1, 1, 1);
		send_coefs(32767, 0, 32767);
		send_coefs(-5, 6, -13);
	endtask

	// The receiver holds off long enough that the result register and the
	// item in work both back up and the coefficient channel stalls.
	task automatic test_backpressure();
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
		hold_off_req = 1'b1;
		gapless = 1'b1;
		repeat (10) begin
			make_random_coefs(a, b, c);
			send_coefs(a, b, c);
		end
		gapless = 1'b0;
	endtask

	task automatic test_random_mix(input int count);
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
		for (int n = 0; n < count; n++) begin
			gapless = ((n / 60) % 4 == 3);
			make_random_coefs(a, b, c);
			send_coefs(a, b, c);
		end
		gapless = 1'b0;
	endtask

	initial begin : receiver
		int free_left;
		int stall_left;
		int hold_left;
		free_left = 0;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				if (free_left == 0 && stall_left == 0) begin
					free_left = ($urandom_range(0, 3) == 0) ?
						$urandom_range(40, 200) : $urandom_range(0, 6);
					stall_left = ($urandom_range(0, 9) == 0) ?
						$urandom_range(10, 60) : $urandom_range(1, 3);
				end
				if (free_left > 0) begin
					result_stall <= 1'b0;
					free_left--;
				end else begin
					result_stall <= 1'b1;
					stall_left--;
				end
			end
		end
	end

	always @(posedge clk) begin : result_checker
		root_set_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_roots.size() == 0) begin
				report_mismatch("result transfer with no coefficients pending");
			end else begin
				want = pending_roots.pop_front();
				check_field("root_kind", root_kind, want.kind);
				check_field("leading_zero", leading_zero, want.lead_zero);
				check_field("perfect_square", perfect_square, want.perfect);
				check_field("disc_magnitude", disc_magnitude, want.mag);
				check_field("disc_root", disc_root, want.root);
				check_field("real_numerator", $unsigned(real_numerator), want.real_num);
				check_field("denominator", $unsigned(denominator), want.den);
				check_field("root_plus_numerator", $unsigned(root_plus_numerator),
					want.plus_num);
				check_field("root_minus_numerator", $unsigned(root_minus_numerator),
					want.minus_num);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_coef_extremes();
		test_leading_zero();
		test_double_root();
		test_real_roots();
		test_complex_roots();
		test_backpressure();
		test_random_mix(915);
		@(negedge clk);
		coef_valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
